[src/minmax_decimator_history_ring_macros.svh]
// Assertion helpers for the min/max decimator.
// Each macro expects clk and arst_n in scope.
`ifndef MINMAX_DECIMATOR_HISTORY_RING_MACROS_SVH
`define MINMAX_DECIMATOR_HISTORY_RING_MACROS_SVH

// cond must hold at every edge outside reset
`define MDHR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define MDHR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MDHR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mdhr_pkg.sv]
package mdhr_pkg;

	localparam int HISTORY_DEPTH = 4096;
	localparam int SAMPLE_WIDTH  = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int NCHAN         = 3;
	localparam int MARKS_W       = 8;
	localparam int SPB_W         = 16;

	localparam logic [SPB_W-1:0] SPB_RESET = 16'd30;

	// input command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// work handed from front to back
	typedef enum logic [1:0] {
		OP_EMPTY, // result with no bin
		OP_BIN,   // completed bin: store and report
		OP_READ   // fetch stored bin
	} op_t;

endpackage

[src/mdhr_fifo.sv]
module mdhr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mdhr_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = slot_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

[src/mdhr_front.sv]
module mdhr_front #(
	parameter int HISTORY_DEPTH = mdhr_pkg::HISTORY_DEPTH,
	parameter int SAMPLE_WIDTH  = mdhr_pkg::SAMPLE_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mdhr_pkg::SPB_W-1:0]             cfg_wdata,
	input  logic                                   accept,
	input  logic                                   cmd,
	input  logic signed [SAMPLE_WIDTH-1:0]         sample_raw,
	input  logic signed [SAMPLE_WIDTH-1:0]         sample_signal,
	input  logic signed [SAMPLE_WIDTH-1:0]         sample_noise,
	input  logic [mdhr_pkg::MARKS_W-1:0]           sample_marks,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]       age,
	output mdhr_pkg::op_t                          op,
	output logic [$clog2(HISTORY_DEPTH)-1:0]       addr,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0]     stored,
	output logic [2*mdhr_pkg::NCHAN*SAMPLE_WIDTH+mdhr_pkg::MARKS_W-1:0] bin
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int NCH    = mdhr_pkg::NCHAN;
	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH+1);
	localparam int SPB_W  = mdhr_pkg::SPB_W;
	localparam int SUM_W  = SLOT_W + 2;
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

	logic [SPB_W-1:0]                spb_q;
	logic [SPB_W-1:0]                fill_q;
	logic signed [SW-1:0]            min_q [NCH];
	logic signed [SW-1:0]            max_q [NCH];
	logic [mdhr_pkg::MARKS_W-1:0]    marks_q;
	logic [SLOT_W-1:0]               slot_q;
	logic [CNT_W-1:0]                filled_q;

	logic signed [SW-1:0]            smp   [NCH];
	logic signed [SW-1:0]            nmin  [NCH];
	logic signed [SW-1:0]            nmax  [NCH];
	logic [mdhr_pkg::MARKS_W-1:0]    nmarks;
	logic [SPB_W:0]                  fill_nx;
	logic [SPB_W-1:0]                need;
	logic                            done;
	logic                            is_read;
	logic                            rd_hit;
	logic [SUM_W-1:0]                rd_sum;
	logic [SUM_W-1:0]                rd_wrap;
	logic [SLOT_W-1:0]               rd_idx;
	logic [SLOT_W-1:0]               slot_nx;
	logic [CNT_W-1:0]                filled_nx;

	assign smp[0] = sample_raw;
	assign smp[1] = sample_signal;
	assign smp[2] = sample_noise;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			nmin[c] = (smp[c] < min_q[c]) ? smp[c] : min_q[c];
			nmax[c] = (smp[c] > max_q[c]) ? smp[c] : max_q[c];
		end
	end

	assign nmarks  = marks_q | sample_marks;
	assign fill_nx = {1'b0, fill_q} + 1'b1;
	// a setting of zero behaves as one
	assign need    = (spb_q == '0) ? SPB_W'(1) : spb_q;
	assign done    = (fill_nx >= {1'b0, need});
	assign is_read = (cmd == mdhr_pkg::CMD_READ);

	// newest bin sits one below the write slot
	assign rd_hit  = (CNT_W'(age) < filled_q);
	assign rd_sum  = SUM_W'(slot_q) + SUM_W'(HISTORY_DEPTH - 1) - SUM_W'(age);
	assign rd_wrap = (rd_sum >= SUM_W'(HISTORY_DEPTH)) ? rd_sum - SUM_W'(HISTORY_DEPTH)
		: rd_sum;
	assign rd_idx  = rd_wrap[SLOT_W-1:0];

	assign slot_nx   = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign filled_nx = (filled_q == CNT_W'(HISTORY_DEPTH)) ? filled_q : filled_q + 1'b1;

	always_comb begin
		op     = mdhr_pkg::OP_EMPTY;
		addr   = slot_q;
		stored = filled_q;
		bin    = '0;
		if (is_read) begin
			op   = rd_hit ? mdhr_pkg::OP_READ : mdhr_pkg::OP_EMPTY;
			addr = rd_idx;
		end else if (done) begin
			op     = mdhr_pkg::OP_BIN;
			stored = filled_nx;
			bin    = {nmin[0], nmax[0], nmin[1], nmax[1], nmin[2], nmax[2], nmarks};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= mdhr_pkg::SPB_RESET;
		end else if (cfg_we) begin
			spb_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				min_q[c] <= SMAX;
				max_q[c] <= SMIN;
			end
			marks_q  <= '0;
			fill_q   <= '0;
			slot_q   <= '0;
			filled_q <= '0;
		end else if (accept && !is_read) begin
			if (done) begin
				for (int c = 0; c < NCH; c++) begin
					min_q[c] <= SMAX;
					max_q[c] <= SMIN;
				end
				marks_q  <= '0;
				fill_q   <= '0;
				slot_q   <= slot_nx;
				filled_q <= filled_nx;
			end else begin
				for (int c = 0; c < NCH; c++) begin
					min_q[c] <= nmin[c];
					max_q[c] <= nmax[c];
				end
				marks_q <= nmarks;
				fill_q  <= fill_nx[SPB_W-1:0];
			end
		end
	end

endmodule

[src/mdhr_back.sv]
module mdhr_back #(
	parameter int HISTORY_DEPTH = mdhr_pkg::HISTORY_DEPTH,
	parameter int SAMPLE_WIDTH  = mdhr_pkg::SAMPLE_WIDTH,
	parameter int QUEUE_DEPTH   = mdhr_pkg::QUEUE_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_avail,
	input  mdhr_pkg::op_t                          cmd_op,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]       cmd_addr,
	input  logic [$clog2(HISTORY_DEPTH+1)-1:0]     cmd_stored,
	input  logic [2*mdhr_pkg::NCHAN*SAMPLE_WIDTH+mdhr_pkg::MARKS_W-1:0] cmd_bin,
	output logic                                   cmd_take,
	input  logic                                   pop,
	output logic                                   empty,
	output logic [2*mdhr_pkg::NCHAN*SAMPLE_WIDTH+mdhr_pkg::MARKS_W-1:0] res_bin,
	output logic                                   res_valid,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0]     res_stored
);

	localparam int BIN_W  = 2*mdhr_pkg::NCHAN*SAMPLE_WIDTH + mdhr_pkg::MARKS_W;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH+1);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH+1);
	localparam int OUT_W  = BIN_W + 1 + CNT_W;

	logic [BIN_W-1:0]  hist_mem [HISTORY_DEPTH];
	logic [BIN_W-1:0]  rd_q;
	logic              valid_s1;
	mdhr_pkg::op_t     op_s1;
	logic [BIN_W-1:0]  bin_s1;
	logic [CNT_W-1:0]  stored_s1;

	logic [BIN_W-1:0]  s1_bin;
	logic              s1_valid;
	logic [QCNT_W-1:0] out_count;
	logic [QCNT_W:0]   in_flight;
	logic [OUT_W-1:0]  out_word;

	// reserve room for the word already in s1
	assign in_flight = {1'b0, out_count} + {{QCNT_W{1'b0}}, valid_s1};
	assign cmd_take  = cmd_avail && (in_flight < (QCNT_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			if (cmd_op == mdhr_pkg::OP_BIN) begin
				hist_mem[cmd_addr] <= cmd_bin;
			end
			rd_q <= hist_mem[cmd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_s1     <= cmd_op;
			bin_s1    <= cmd_bin;
			stored_s1 <= cmd_stored;
		end
	end

	always_comb begin
		unique case (op_s1)
			mdhr_pkg::OP_BIN: begin
				s1_bin   = bin_s1;
				s1_valid = 1'b1;
			end
			mdhr_pkg::OP_READ: begin
				s1_bin   = rd_q;
				s1_valid = 1'b1;
			end
			default: begin
				s1_bin   = '0;
				s1_valid = 1'b0;
			end
		endcase
	end

	mdhr_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.wdata  ({s1_bin, s1_valid, stored_s1}),
		.pop    (pop),
		.rdata  (out_word),
		.full   (),
		.empty  (empty),
		.count  (out_count)
	);

	assign res_bin    = out_word[OUT_W-1 -: BIN_W];
	assign res_valid  = out_word[CNT_W];
	assign res_stored = out_word[CNT_W-1:0];

endmodule

[src/minmax_decimator_history_ring.sv]
// Min/max peak-detect decimator with a history ring of completed bins.
// Input side is a queue write port: present a word and raise push; it is taken
// on a rising edge with push high and full low. cmd selects a feature sample
// (folded into the running bin of three channels plus the marks byte) or a
// read of the stored bin 'age' bins back from the newest.
// Result side is a queue read port: while empty is low the oldest result is on
// the result ports; pop high at an edge with empty low takes it. Every input
// word yields exactly one result word, in order.
// Throughput: one word per cycle, sustained, as long as results are popped.
// A taken word passes the front update and command queue write, then the ring RAM
// access, then the result queue, where the result becomes visible.
// The ring RAM has one write/read port, used by one command per cycle.
// When pop is held low the result queue fills, the back end stops pulling
// commands, the command queue fills, and full rises; nothing is dropped.
// Reset (arst_n low) clears the running bin, write slot, bin count, both
// queues and sets samples_per_bin to 30. The ring RAM is not cleared; reads
// only ever reach slots already written. cfg_we writes samples_per_bin
// directly; change it only while the block is idle.
`include "minmax_decimator_history_ring_macros.svh"

module minmax_decimator_history_ring #(
	parameter int HISTORY_DEPTH = mdhr_pkg::HISTORY_DEPTH,
	parameter int SAMPLE_WIDTH  = mdhr_pkg::SAMPLE_WIDTH,
	parameter int QUEUE_DEPTH   = mdhr_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [mdhr_pkg::SPB_W-1:0]         cfg_wdata,
	// input queue port
	input  logic                               push,
	output logic                               full,
	input  logic                               cmd,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample_raw,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample_signal,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample_noise,
	input  logic [mdhr_pkg::MARKS_W-1:0]       sample_marks,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]   age,
	// result queue port
	output logic                               empty,
	input  logic                               pop,
	output logic signed [SAMPLE_WIDTH-1:0]     min_raw,
	output logic signed [SAMPLE_WIDTH-1:0]     max_raw,
	output logic signed [SAMPLE_WIDTH-1:0]     min_signal,
	output logic signed [SAMPLE_WIDTH-1:0]     max_signal,
	output logic signed [SAMPLE_WIDTH-1:0]     min_noise,
	output logic signed [SAMPLE_WIDTH-1:0]     max_noise,
	output logic [mdhr_pkg::MARKS_W-1:0]       bin_marks,
	output logic                               bin_valid,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0] bins_stored
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int MW     = mdhr_pkg::MARKS_W;
	localparam int BIN_W  = 2*mdhr_pkg::NCHAN*SW + MW;
	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH+1);
	localparam int OP_W   = $bits(mdhr_pkg::op_t);
	localparam int CMD_W  = OP_W + SLOT_W + CNT_W + BIN_W;

	logic              accept;

	// front -> command queue
	mdhr_pkg::op_t     f_op;
	logic [SLOT_W-1:0] f_addr;
	logic [CNT_W-1:0]  f_stored;
	logic [BIN_W-1:0]  f_bin;

	// command queue -> back
	logic [CMD_W-1:0]  q_word;
	logic              q_empty;
	logic              q_take;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	logic [BIN_W-1:0]  r_bin;

	assign accept = push && !full;

	mdhr_front #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.cmd           (cmd),
		.sample_raw    (sample_raw),
		.sample_signal (sample_signal),
		.sample_noise  (sample_noise),
		.sample_marks  (sample_marks),
		.age           (age),
		.op            (f_op),
		.addr          (f_addr),
		.stored        (f_stored),
		.bin           (f_bin)
	);

	// short queue decoupling the classifier from the ring RAM
	mdhr_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  ({f_op, f_addr, f_stored, f_bin}),
		.pop    (q_take),
		.rdata  (q_word),
		.full   (full),
		.empty  (q_empty),
		.count  (q_count)
	);

	mdhr_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.QUEUE_DEPTH   (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (!q_empty),
		.cmd_op     (mdhr_pkg::op_t'(q_word[CMD_W-1 -: OP_W])),
		.cmd_addr   (q_word[CNT_W+BIN_W +: SLOT_W]),
		.cmd_stored (q_word[BIN_W +: CNT_W]),
		.cmd_bin    (q_word[BIN_W-1:0]),
		.cmd_take   (q_take),
		.pop        (pop),
		.empty      (empty),
		.res_bin    (r_bin),
		.res_valid  (bin_valid),
		.res_stored (bins_stored)
	);

	assign min_raw    = r_bin[BIN_W-1      -: SW];
	assign max_raw    = r_bin[BIN_W-1-SW   -: SW];
	assign min_signal = r_bin[BIN_W-1-2*SW -: SW];
	assign max_signal = r_bin[BIN_W-1-3*SW -: SW];
	assign min_noise  = r_bin[BIN_W-1-4*SW -: SW];
	assign max_noise  = r_bin[BIN_W-1-5*SW -: SW];
	assign bin_marks  = r_bin[MW-1:0];

	// a queued command never outlives the queue's own bookkeeping
	`MDHR_ASSERT_IMPLIES(a_cmdq_count, !q_empty, q_count != '0, "command queue count lost")

	// a word with no bin carries all-zero extremes and marks
	`MDHR_ASSERT_IMPLIES(a_empty_bin_zero, !empty && !bin_valid, r_bin == '0, "invalid result carries data")

	// bins_stored never goes down from one result to the next
	`MDHR_ASSERT_NEXT(a_stored_mono, pop && !empty, empty || bins_stored >= $past(bins_stored), "bin count went backwards")

	`MDHR_ASSERT_ALWAYS(a_stored_range, empty || bins_stored <= CNT_W'(HISTORY_DEPTH), "bin count above ring depth")

endmodule

[test/mdhr_bin_checker.sv]
`timescale 1ns / 1ps

// Watches the input, result and config ports of the min/max decimator.
// It keeps its own copy of the running bin and the history ring, and queues
// one expected result word per accepted input word.
module mdhr_bin_checker
	import mdhr_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [SPB_W-1:0]                   cfg_wdata,
	input  logic                               push,
	input  logic                               full,
	input  logic                               cmd,
	input  logic [SAMPLE_WIDTH-1:0]            sample_raw,
	input  logic [SAMPLE_WIDTH-1:0]            sample_signal,
	input  logic [SAMPLE_WIDTH-1:0]            sample_noise,
	input  logic [MARKS_W-1:0]                 sample_marks,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]   age,
	input  logic                               empty,
	input  logic                               pop,
	input  logic [SAMPLE_WIDTH-1:0]            min_raw,
	input  logic [SAMPLE_WIDTH-1:0]            max_raw,
	input  logic [SAMPLE_WIDTH-1:0]            min_signal,
	input  logic [SAMPLE_WIDTH-1:0]            max_signal,
	input  logic [SAMPLE_WIDTH-1:0]            min_noise,
	input  logic [SAMPLE_WIDTH-1:0]            max_noise,
	input  logic [MARKS_W-1:0]                 bin_marks,
	input  logic                               bin_valid,
	input  logic [$clog2(HISTORY_DEPTH+1)-1:0] bins_stored,
	output int                                 errors,
	output int                                 outstanding
);

	localparam int W      = SAMPLE_WIDTH;
	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH+1);

	typedef struct packed {
		logic [NCHAN-1:0][W-1:0] lo;
		logic [NCHAN-1:0][W-1:0] hi;
		logic [MARKS_W-1:0]      marks;
	} bin_t;

	typedef struct packed {
		bin_t                                 b;
		logic                                 valid;
		logic [$clog2(HISTORY_DEPTH+1)-1:0]   stored;
	} result_t;

	bin_t    ring [HISTORY_DEPTH];
	bin_t    run;
	int      run_count;
	int      slot;
	int      filled;
	int      spb;
	result_t owed [$];

	// empty bin: min at most positive, max at most negative
	function automatic bin_t fresh_bin();
		bin_t f;
		for (int c = 0; c < NCHAN; c++) begin
			f.lo[c] = {1'b0, {(W-1){1'b1}}};
			f.hi[c] = {1'b1, {(W-1){1'b0}}};
		end
		f.marks = '0;
		return f;
	endfunction

	task automatic flag(input string what);
		errors++;
		$display("checker: %0t ns: %s", $realtime, what);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			flag($sformatf("%s: got %h, expected %h", name, got, want));
	endtask

	// fold a sample into the running bin or fetch a stored bin
	task automatic fold_word(input logic kind, input logic [NCHAN-1:0][W-1:0] s,
			input logic [MARKS_W-1:0] m, input int back);
		result_t r;
		int      need;
		r = '0;
		if (kind == CMD_READ) begin
			if (back < filled) begin
				r.b     = ring[SLOT_W'((slot + HISTORY_DEPTH - 1 - back) % HISTORY_DEPTH)];
				r.valid = 1'b1;
			end
		end else begin
			for (int c = 0; c < NCHAN; c++) begin
				if ($signed(s[c]) < $signed(run.lo[c]))
					run.lo[c] = s[c];
				if ($signed(s[c]) > $signed(run.hi[c]))
					run.hi[c] = s[c];
			end
			run.marks |= m;
			run_count++;
			need = (spb == 0) ? 1 : spb;
			if (run_count >= need) begin
				ring[SLOT_W'(slot)] = run;
				slot = (slot + 1) % HISTORY_DEPTH;
				if (filled < HISTORY_DEPTH)
					filled++;
				r.b       = run;
				r.valid   = 1'b1;
				run       = fresh_bin();
				run_count = 0;
			end
		end
		r.stored = CNT_W'(filled);
		owed.push_back(r);
	endtask

	task automatic check_result();
		result_t want;
		if (owed.size() == 0) begin
			flag("result word with nothing expected");
		end else begin
			want = owed.pop_front();
			compare_field("min_raw", min_raw, want.b.lo[0]);
			compare_field("max_raw", max_raw, want.b.hi[0]);
			compare_field("min_signal", min_signal, want.b.lo[1]);
			compare_field("max_signal", max_signal, want.b.hi[1]);
			compare_field("min_noise", min_noise, want.b.lo[2]);
			compare_field("max_noise", max_noise, want.b.hi[2]);
			compare_field("bin_marks", 16'(bin_marks), 16'(want.b.marks));
			compare_field("bin_valid", 16'(bin_valid), 16'(want.valid));
			compare_field("bins_stored", 16'(bins_stored), 16'(want.stored));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run         = fresh_bin();
			run_count   = 0;
			slot        = 0;
			filled      = 0;
			spb         = int'(SPB_RESET);
			errors      = 0;
			owed.delete();
			outstanding <= 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				fold_word(cmd, {sample_noise, sample_signal, sample_raw}, sample_marks,
					int'(age));
			if (cfg_we)
				spb = int'(cfg_wdata);
			outstanding <= owed.size();
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the min/max decimator. All checking lives in
// mdhr_bin_checker; this module only drives ports and decides pass/fail.
module tb_top;
	import mdhr_pkg::*;

	localparam int IDLE_PCT    = 15;    // idle odds per cycle, each side
	localparam int QUIET_LIMIT = 2000;  // cycles with no word moving
	localparam int FILL_WORDS  = 120;   // one-sample bins sent with no idling
	localparam int SETTLE      = 8;     // tail after drain

	typedef struct packed {
		logic        kind;
		logic [15:0] raw;
		logic [15:0] sig;
		logic [15:0] noise;
		logic [7:0]  marks;
		logic [11:0] back;
	} word_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [15:0] cfg_wdata     = '0;
	logic        push          = 1'b0;
	logic        cmd           = CMD_SAMPLE;
	logic [15:0] sample_raw    = '0;
	logic [15:0] sample_signal = '0;
	logic [15:0] sample_noise  = '0;
	logic [7:0]  sample_marks  = '0;
	logic [11:0] age           = '0;
	logic        pop           = 1'b0;
	logic        steady        = 1'b0;  // high: neither side idles

	logic        full;
	logic        empty;
	logic [15:0] min_raw;
	logic [15:0] max_raw;
	logic [15:0] min_signal;
	logic [15:0] max_signal;
	logic [15:0] min_noise;
	logic [15:0] max_noise;
	logic [7:0]  bin_marks;
	logic        bin_valid;
	logic [12:0] bins_stored;

	int errors;
	int outstanding;
	int quiet = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	minmax_decimator_history_ring dut (.*);

	mdhr_bin_checker chk (.*);

	// result side: pop most cycles, never idles during the steady stretch
	always @(posedge clk) begin
		pop <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog: any accepted word on either side resets the count
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic breather();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// channel level: rails often, otherwise any code
	function automatic logic [15:0] pick_level();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// ages mostly within age_span so reads tend to hit stored bins
	function automatic word_t pick_word(int read_pct, int age_span);
		word_t w;
		w.kind  = ($urandom_range(99) < read_pct) ? CMD_READ : CMD_SAMPLE;
		w.raw   = pick_level();
		w.sig   = pick_level();
		w.noise = pick_level();
		w.marks = 8'($urandom);
		w.back  = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(age_span - 1));
		return w;
	endfunction

	function automatic word_t sample_word(logic [15:0] raw, logic [15:0] sig,
			logic [15:0] noise, logic [7:0] marks);
		word_t w;
		w       = '0;
		w.kind  = CMD_SAMPLE;
		w.raw   = raw;
		w.sig   = sig;
		w.noise = noise;
		w.marks = marks;
		return w;
	endfunction

	function automatic word_t read_word(logic [11:0] back);
		word_t w;
		w       = pick_word(100, 1);  // random payload, which a read ignores
		w.kind  = CMD_READ;
		w.back  = back;
		return w;
	endfunction

	// Present one word and hold it until taken. push is left high on return so
	// back-to-back words go out without a bubble; an idle gap lowers it first.
	task automatic send(input word_t w);
		if (breather()) begin
			push <= 1'b0;
			do @(posedge clk); while (breather());
		end
		push          <= 1'b1;
		cmd           <= w.kind;
		sample_raw    <= w.raw;
		sample_signal <= w.sig;
		sample_noise  <= w.noise;
		sample_marks  <= w.marks;
		age           <= w.back;
		do @(posedge clk); while (full);
	endtask

	// Stop pushing and wait for every expected word to come out. The count from
	// the checker is registered, so the first edge here covers the last push.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_spb(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_run(input int n, input logic [15:0] spb, input int read_pct,
			input int age_span);
		drain();
		write_spb(spb);
		repeat (n) send(pick_word(read_pct, age_span));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// nothing stored yet: both ends of the age range read back invalid
		send(read_word(12'd0));
		send(read_word(12'hFFF));
		// partial bin at the reset setting of 30: rails and zero
		send(sample_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h01));
		send(sample_word(16'h8000, 16'h8000, 16'h8000, 8'h80));
		send(sample_word(16'h0000, 16'h0000, 16'h0000, 8'h00));
		// setting dropped below the partial count: next sample closes the bin
		drain();
		write_spb(16'd1);
		send(sample_word(16'h7FFF, 16'h8000, 16'h1234, 8'hFF));
		send(read_word(12'd0));
		send(read_word(12'd1));
		// zero setting behaves as one: every sample is its own bin
		drain();
		write_spb(16'd0);
		send(sample_word(16'hFFFF, 16'h0001, 16'h8000, 8'h5A));
		send(sample_word(16'h0001, 16'hFFFF, 16'h7FFF, 8'hA5));
		send(read_word(12'd2));
		send(read_word(12'd3));
		// largest setting: samples pile up without closing a bin
		drain();
		write_spb(16'hFFFF);
		send(sample_word(16'h4000, 16'hC000, 16'h0000, 8'h10));
		send(sample_word(16'hC000, 16'h4000, 16'h0000, 8'h20));
		send(sample_word(16'h0000, 16'h0000, 16'hFFFF, 8'h40));
		drain();
		write_spb(16'd2);
		send(sample_word(16'h0002, 16'h0002, 16'h0002, 8'h02));
		send(read_word(12'd0));

		// --- random, over a spread of bin sizes ---
		random_run(50, 16'd3, 30, 8);
		random_run(50, 16'd1, 30, 32);
		random_run(40, 16'd0, 30, 64);
		random_run(50, 16'd7, 25, 16);
		random_run(50, 16'd30, 25, 16);
		random_run(30, 16'hFFFF, 25, 16);
		random_run(50, 16'd2, 30, 64);
		random_run(50, 16'd5, 30, 32);

		// Long stretch of one-sample bins with no idling on either side.
		drain();
		write_spb(16'd1);
		steady <= 1'b1;
		repeat (FILL_WORDS) send(pick_word(0, 1));
		steady <= 1'b0;
		send(read_word(12'hFFF));
		send(read_word(12'd0));

		// reads spread over the stored bins and beyond them
		random_run(60, 16'd1, 40, 256);
		random_run(30, 16'd4, 40, 256);

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/mdhr_pkg.sv
src/mdhr_fifo.sv
src/mdhr_front.sv
src/mdhr_back.sv
src/minmax_decimator_history_ring.sv
test/mdhr_bin_checker.sv
test/tb_top.sv
